@@ hw/rtl/rpn_pkg.sv @@
// rpn_pkg: shared types, sizes and the microcode ROM of the RPN stack evaluator.
// Used by all files but rpn_ram (the bench imports it); depends on nothing.

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DEPTH_W     = 7;
    localparam int CMD_W       = 3;
    localparam int ST_W        = 3;
    localparam int DIV_STEPS   = DATA_W + FRAC_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
    localparam int ACC_W       = DIV_STEPS + 1;
    localparam int PC_W        = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_FIN  = 3'd5
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ZDIV    = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_OVF     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ZERO,
        J_BUSY
    } t_jmp;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_IN,
        WR_RES
    } t_wr;

    // one control word per microcode step
    typedef struct packed {
        logic            pop;
        logic            ld_rhs;
        logic            ld_lhs;
        logic            div_go;
        t_alu            alu;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
        t_wr             wr;
        logic            fin;
        t_status         st;
        logic            done;
    } t_cw;

    typedef struct packed {
        logic rhs_zero;
        logic div_busy;
    } t_cond;

    // microcode entry points
    localparam logic [PC_W-1:0] PC_PUSH = 5'd0;
    localparam logic [PC_W-1:0] PC_ADD  = 5'd1;
    localparam logic [PC_W-1:0] PC_SUB  = 5'd6;
    localparam logic [PC_W-1:0] PC_MUL  = 5'd11;
    localparam logic [PC_W-1:0] PC_DIV  = 5'd16;
    localparam logic [PC_W-1:0] PC_DWT  = 5'd22;
    localparam logic [PC_W-1:0] PC_ZDIV = 5'd25;
    localparam logic [PC_W-1:0] PC_FIN  = 5'd26;
    localparam logic [PC_W-1:0] PC_UNK  = 5'd29;

    function automatic logic [PC_W-1:0] entry_pc(input logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_PUSH: pc = PC_PUSH;
            CMD_ADD:  pc = PC_ADD;
            CMD_SUB:  pc = PC_SUB;
            CMD_MUL:  pc = PC_MUL;
            CMD_DIV:  pc = PC_DIV;
            CMD_FIN:  pc = PC_FIN;
            default:  pc = PC_UNK;
        endcase
        return pc;
    endfunction

    function automatic t_cw ucode(input logic [PC_W-1:0] pc);
        t_cw cw;
        cw        = '0;
        cw.alu    = ALU_NONE;
        cw.jmp    = J_NEXT;
        cw.wr     = WR_NONE;
        cw.st     = ST_OK;
        case (pc)
            // push
            5'd0:  begin cw.wr = WR_IN; cw.done = 1'b1; end
            // add
            5'd1:  begin cw.pop = 1'b1; end
            5'd2:  begin cw.ld_rhs = 1'b1; cw.pop = 1'b1; end
            5'd3:  begin cw.ld_lhs = 1'b1; end
            5'd4:  begin cw.alu = ALU_ADD; end
            5'd5:  begin cw.wr = WR_RES; cw.done = 1'b1; end
            // subtract
            5'd6:  begin cw.pop = 1'b1; end
            5'd7:  begin cw.ld_rhs = 1'b1; cw.pop = 1'b1; end
            5'd8:  begin cw.ld_lhs = 1'b1; end
            5'd9:  begin cw.alu = ALU_SUB; end
            5'd10: begin cw.wr = WR_RES; cw.done = 1'b1; end
            // multiply
            5'd11: begin cw.pop = 1'b1; end
            5'd12: begin cw.ld_rhs = 1'b1; cw.pop = 1'b1; end
            5'd13: begin cw.ld_lhs = 1'b1; end
            5'd14: begin cw.alu = ALU_MUL; end
            5'd15: begin cw.wr = WR_RES; cw.done = 1'b1; end
            // divide: divisor first, bail out on zero before popping the dividend
            5'd16: begin cw.pop = 1'b1; end
            5'd17: begin cw.ld_rhs = 1'b1; end
            5'd18: begin cw.jmp = J_ZERO; cw.target = PC_ZDIV; end
            5'd19: begin cw.pop = 1'b1; end
            5'd20: begin cw.ld_lhs = 1'b1; end
            5'd21: begin cw.div_go = 1'b1; end
            5'd22: begin cw.jmp = J_BUSY; cw.target = PC_DWT; end
            5'd23: begin cw.alu = ALU_DIV; end
            5'd24: begin cw.wr = WR_RES; cw.done = 1'b1; end
            5'd25: begin cw.st = ST_ZDIV; cw.done = 1'b1; end
            // finish
            5'd26: begin cw.pop = 1'b1; end
            5'd27: begin cw.ld_rhs = 1'b1; end
            5'd28: begin cw.fin = 1'b1; cw.done = 1'b1; end
            // unknown command
            5'd29: begin cw.st = ST_UNKNOWN; cw.done = 1'b1; end
            default: begin cw.st = ST_UNKNOWN; cw.done = 1'b1; end
        endcase
        return cw;
    endfunction

endpackage

@@ hw/rtl/rpn_if.sv @@
// rpn_if: valid/ready channel interfaces for command words and result words.
// Depends on rpn_pkg for field widths.

interface rpn_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rpn_pkg::CMD_W-1:0]            cmd;
    logic signed [rpn_pkg::DATA_W-1:0]    operand_value;

    modport source (output valid, output cmd, output operand_value, input ready);
    modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

interface rpn_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rpn_pkg::ST_W-1:0]             status;
    logic signed [rpn_pkg::DATA_W-1:0]    top_value;
    logic [rpn_pkg::DEPTH_W-1:0]          depth;

    modport source (output valid, output status, output top_value, output depth, input ready);
    modport sink   (input valid, input status, input top_value, input depth, output ready);
endinterface

@@ hw/rtl/rpn_stack_calculator_core.sv @@
// rpn_stack_calculator_core: RPN evaluator, signed Q16.16, 64-entry operand stack.
// One word at a time: word accepted, then microcode steps, a divide waiting on the
// bit-serial divider; result word valid the cycle after the last step. Next word taken
// once the result is stored. Reset (i_rst_n, synchronous, low) empties the stack and
// clears control; stack RAM is not cleared, since only entries below the count are ever used.

module rpn_stack_calculator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_in_if.sink     i_in,
    rpn_out_if.source  o_out
);

    localparam int DW = rpn_pkg::DATA_W;
    localparam int AW = rpn_pkg::ADDR_W;
    localparam int CW = rpn_pkg::CNT_W;
    localparam int XW = rpn_pkg::ACC_W;

    // ---------------------------------------------------------------- control
    rpn_pkg::t_cw     w_cw;
    rpn_pkg::t_cond   w_cond;
    logic             w_run;
    logic             w_start;
    logic             w_hold;
    logic             w_act;     // current step takes effect this cycle

    // ---------------------------------------------------------------- datapath
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic signed [DW-1:0]   r_opnd;
    logic signed [DW-1:0]   r_lhs;
    logic signed [DW-1:0]   r_rhs;
    logic signed [XW-1:0]   r_acc;
    logic                   r_uf;       // some pop of this word hit an empty stack
    logic                   r_pop_uf;   // the last pop hit an empty stack
    logic [DW-1:0]          w_rdata;
    logic signed [DW-1:0]   w_popped;
    logic                   w_empty;
    logic [AW-1:0]          w_pop_addr;
    logic                   w_we;
    logic signed [DW-1:0]   w_wdata;
    logic signed [2*DW-1:0] w_prod;
    logic signed [XW-1:0]   w_quot;
    logic                   w_div_busy;
    logic signed [DW-1:0]   w_sat;
    logic                   w_ovf;
    logic                   w_sat_hi;
    logic                   w_sat_lo;

    // ---------------------------------------------------------------- result word
    logic                     r_ovalid;
    rpn_pkg::t_status         r_status;
    logic signed [DW-1:0]     r_top;
    logic [rpn_pkg::DEPTH_W-1:0] r_depth;
    rpn_pkg::t_status         w_status;
    logic signed [DW-1:0]     w_top;

    assign i_in.ready = !w_run;
    assign w_start    = i_in.valid && !w_run;

    // the final step waits while the previous result word is still unclaimed
    assign w_hold = w_cw.done && r_ovalid && !o_out.ready;
    assign w_act  = w_run && !w_hold;

    assign w_cond.rhs_zero = (r_rhs == '0);
    assign w_cond.div_busy = w_div_busy;

    rpn_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (i_in.cmd),
        .i_cond  (w_cond),
        .i_hold  (w_hold),
        .o_cw    (w_cw),
        .o_run   (w_run)
    );

    // ---------------------------------------------------------------- stack memory
    assign w_empty    = (r_count == '0);
    assign w_pop_addr = r_count[AW-1:0] - 1'b1;
    assign w_popped   = r_pop_uf ? '0 : $signed(w_rdata);

    // saturate the wide accumulator to Q16.16
    assign w_sat_hi = !r_acc[XW-1] && (|r_acc[XW-2:DW-1]);
    assign w_sat_lo = r_acc[XW-1] && !(&r_acc[XW-2:DW-1]);
    assign w_ovf    = w_sat_hi || w_sat_lo;
    always_comb begin
        if (w_sat_hi) begin
            w_sat = {1'b0, {(DW-1){1'b1}}};
        end else if (w_sat_lo) begin
            w_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            w_sat = r_acc[DW-1:0];
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_sat;
        case (w_cw.wr)
            rpn_pkg::WR_IN: begin
                w_we    = w_act && (r_count < CW'(rpn_pkg::STACK_DEPTH));
                w_wdata = r_opnd;
            end
            rpn_pkg::WR_RES: begin
                w_we    = w_act;
                w_wdata = w_sat;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    rpn_ram #(
        .WIDTH (DW),
        .DEPTH (rpn_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_act && w_cw.pop),
        .i_raddr (w_pop_addr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------- arithmetic
    assign w_prod = r_lhs * r_rhs;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_act && w_cw.div_go),
        .i_lhs   (r_lhs),
        .i_rhs   (r_rhs),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // ---------------------------------------------------------------- count
    always_comb begin
        n_count = r_count;
        if (w_act) begin
            if (w_cw.pop && !w_empty) begin
                n_count = r_count - 1'b1;
            end
            if (w_we) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- result fields
    always_comb begin
        w_status = w_cw.st;
        w_top    = '0;
        case (w_cw.wr)
            rpn_pkg::WR_IN: begin
                if (r_count < CW'(rpn_pkg::STACK_DEPTH)) begin
                    w_top = r_opnd;
                end else begin
                    w_status = rpn_pkg::ST_FULL;
                end
            end
            rpn_pkg::WR_RES: begin
                w_top = w_sat;
                if (w_ovf) begin
                    w_status = rpn_pkg::ST_OVF;
                end
            end
            default: begin
                if (w_cw.fin) begin
                    w_top = r_rhs;
                end
            end
        endcase
        // an empty-stack pop outranks every other status
        if (r_uf) begin
            w_status = rpn_pkg::ST_EMPTY;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_uf     <= 1'b0;
            r_pop_uf <= 1'b0;
        end else begin
            r_count <= n_count;
            // a new result word replaces one taken in the same cycle
            if (w_act && w_cw.done) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_start) begin
                r_opnd <= i_in.operand_value;
                r_uf   <= 1'b0;
            end
            if (w_act) begin
                if (w_cw.pop) begin
                    r_pop_uf <= w_empty;
                    if (w_empty) begin
                        r_uf <= 1'b1;
                    end
                end
                if (w_cw.ld_rhs) begin
                    r_rhs <= w_popped;
                end
                if (w_cw.ld_lhs) begin
                    r_lhs <= w_popped;
                end
                case (w_cw.alu)
                    rpn_pkg::ALU_ADD: r_acc <= XW'(r_lhs) + XW'(r_rhs);
                    rpn_pkg::ALU_SUB: r_acc <= XW'(r_lhs) - XW'(r_rhs);
                    // floor shift of the 64-bit product by 16
                    rpn_pkg::ALU_MUL: r_acc <= {w_prod[2*DW-1], w_prod[2*DW-1:rpn_pkg::FRAC_W]};
                    rpn_pkg::ALU_DIV: r_acc <= w_quot;
                    default:          r_acc <= r_acc;
                endcase
                if (w_cw.done) begin
                    r_status <= w_status;
                    r_top    <= w_top;
                    r_depth  <= rpn_pkg::DEPTH_W'(n_count);
                end
            end
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_status;
    assign o_out.top_value = r_top;
    assign o_out.depth     = r_depth;

endmodule

@@ hw/rtl/rpn_ram.sv @@
// rpn_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rpn_div.sv @@
// rpn_div: radix-2 restoring divider, lhs * 2^16 / rhs, one quotient bit per cycle.
// Depends on rpn_pkg for widths.

module rpn_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [rpn_pkg::DATA_W-1:0] i_lhs,
    input  logic signed [rpn_pkg::DATA_W-1:0] i_rhs,
    output logic                              o_busy,
    output logic signed [rpn_pkg::ACC_W-1:0]  o_quot
);

    localparam int DW = rpn_pkg::DATA_W;
    localparam int QW = rpn_pkg::DIV_STEPS;

    logic [QW-1:0]                 r_dvd;   // dividend bits out, quotient bits in
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_dvs;
    logic [rpn_pkg::DCNT_W-1:0]    r_cnt;
    logic                          r_busy;
    logic                          r_neg;
    logic [DW:0]                   w_trial;
    logic [DW:0]                   w_diff;
    logic                          w_fit;
    logic [DW-1:0]                 w_lmag;
    logic [DW-1:0]                 w_rmag;
    logic [QW-1:0]                 n_dvd;
    logic [DW-1:0]                 n_rem;

    // magnitudes as unsigned; the most negative value maps to 2^31
    assign w_lmag = i_lhs[DW-1] ? DW'(-i_lhs) : DW'(i_lhs);
    assign w_rmag = i_rhs[DW-1] ? DW'(-i_rhs) : DW'(i_rhs);

    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_dvd = {r_dvd[QW-2:0], w_fit};
        n_rem = w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= rpn_pkg::DCNT_W'(QW);
            r_dvd  <= {w_lmag, {rpn_pkg::FRAC_W{1'b0}}};
            r_rem  <= '0;
            r_dvs  <= w_rmag;
            r_neg  <= i_lhs[DW-1] ^ i_rhs[DW-1];
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == rpn_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

@@ hw/rtl/rpn_useq.sv @@
// rpn_useq: microcode sequencer, step counter over the ROM in rpn_pkg with
// conditional jumps. Depends on rpn_pkg.

module rpn_useq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpn_pkg::CMD_W-1:0]  i_cmd,
    input  rpn_pkg::t_cond             i_cond,
    input  logic                       i_hold,
    output rpn_pkg::t_cw               o_cw,
    output logic                       o_run
);

    logic [rpn_pkg::PC_W-1:0] r_pc;
    logic                     r_run;
    rpn_pkg::t_cw             w_cw;
    logic                     w_take;

    assign w_cw = rpn_pkg::ucode(r_pc);

    always_comb begin
        case (w_cw.jmp)
            rpn_pkg::J_ZERO: w_take = i_cond.rhs_zero;
            rpn_pkg::J_BUSY: w_take = i_cond.div_busy;
            default:         w_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= '0;
        end else if (!r_run) begin
            if (i_start) begin
                r_run <= 1'b1;
                r_pc  <= rpn_pkg::entry_pc(i_cmd);
            end
        end else if (!i_hold) begin
            if (w_cw.done) begin
                r_run <= 1'b0;
            end else if (w_take) begin
                r_pc <= w_cw.target;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    assign o_cw  = w_cw;
    assign o_run = r_run;

endmodule

@@ dv/tb_rpn_stack_calculator_core.sv @@
// tb_rpn_stack_calculator_core: self-checking bench for the RPN stack evaluator core.
// Needs rpn_pkg, rpn_if and rpn_stack_calculator_core; a local Q16.16 stack
// predictor checks every result word.

module tb_rpn_stack_calculator_core;
    import rpn_pkg::*;

    // the two encodings the command set leaves unassigned
    localparam logic [CMD_W-1:0] CMD_UNK_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNK_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE      = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_LSB      = 32'sh0000_0001;
    localparam logic signed [DATA_W-1:0] Q_NEG_LSB  = 32'shFFFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_NEG_HALF = 32'shFFFF_8000;
    localparam logic signed [DATA_W-1:0] Q_NEG_ONE  = 32'shFFFF_0000;

    // two copies of the stack: one follows the words the DUT takes,
    // one follows the words as they are generated
    localparam int VIEW_DUT = 0;
    localparam int VIEW_GEN = 1;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 70;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
    } calc_cmd_t;

    typedef struct {
        t_status                  st;
        logic signed [DATA_W-1:0] top;
        logic [DEPTH_W-1:0]       depth;
    } calc_word_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    rpn_in_if  in_bus ();
    rpn_out_if out_bus ();

    rpn_stack_calculator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    logic signed [DATA_W-1:0] stk_ent [2][STACK_DEPTH];
    int unsigned              stk_cnt [2];

    calc_cmd_t  cmd_backlog [$];
    calc_word_t predicted_answers [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned hold_left     = 0;
    bit          in_took       = 1'b0;
    int unsigned quiet_cycles  = 0;
    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned cmd_hits [8];
    int unsigned status_hits [8];

    initial begin : clk_gen
        i_clk                = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.cmd           = CMD_PUSH;
        in_bus.operand_value = '0;
        out_bus.ready        = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint pop_operand(input int view, inout bit under);
        if (stk_cnt[view] == 0) begin
            under = 1'b1;
            return 0;
        end
        stk_cnt[view]--;
        return longint'(stk_ent[view][stk_cnt[view]]);
    endfunction

    // applies one command word to a stack copy and returns the word the core should emit
    function automatic calc_word_t evaluate_word(input int view, input logic [CMD_W-1:0] cmd,
                                                 input logic signed [DATA_W-1:0] val);
        calc_word_t w;
        bit         under;
        bit         ovf;
        longint     rhs;
        longint     lhs;
        longint     wide;
        w.st  = ST_OK;
        w.top = '0;
        under = 1'b0;
        ovf   = 1'b0;
        case (cmd)
            CMD_PUSH: begin
                if (stk_cnt[view] < STACK_DEPTH) begin
                    stk_ent[view][stk_cnt[view]] = val;
                    stk_cnt[view]++;
                    w.top = val;
                end else begin
                    w.st = ST_FULL;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                rhs = pop_operand(view, under);
                if (cmd == CMD_DIV && rhs == 0) begin
                    // divisor lost, dividend left in place
                    w.st = ST_ZDIV;
                end else begin
                    lhs = pop_operand(view, under);
                    case (cmd)
                        CMD_ADD: wide = lhs + rhs;
                        CMD_SUB: wide = lhs - rhs;
                        CMD_MUL: wide = (lhs * rhs) >>> FRAC_W;    // floor
                        default: wide = (lhs * 65536) / rhs;       // toward zero
                    endcase
                    if (wide > longint'(Q_MAX)) begin
                        wide = longint'(Q_MAX);
                        ovf  = 1'b1;
                    end else if (wide < longint'(Q_MIN)) begin
                        wide = longint'(Q_MIN);
                        ovf  = 1'b1;
                    end
                    stk_ent[view][stk_cnt[view]] = wide[DATA_W-1:0];
                    stk_cnt[view]++;
                    w.top = wide[DATA_W-1:0];
                    if (ovf) w.st = ST_OVF;
                end
            end
            CMD_FIN: begin
                lhs   = pop_operand(view, under);
                w.top = lhs[DATA_W-1:0];
            end
            default: w.st = ST_UNKNOWN;
        endcase
        if (under) w.st = ST_EMPTY;
        w.depth = stk_cnt[view][DEPTH_W-1:0];
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_q16();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12) return '0;
        if (r < 24) begin
            case ($urandom_range(0, 6))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return Q_ONE;
                3: return Q_LSB;
                4: return Q_NEG_LSB;
                5: return Q_NEG_HALF;
                default: return Q_NEG_ONE;
            endcase
        end
        // mostly modest magnitudes, so that sums and products stay in range
        if (r < 60) return int'($urandom_range(0, 16 * 65536)) - 8 * 65536;
        return $urandom;
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
        calc_word_t dummy;
        cmd_backlog.push_back('{cmd: cmd, val: val});
        dummy = evaluate_word(VIEW_GEN, cmd, val);
    endtask

    // expression-like traffic: pushes and operators balanced around a shallow stack,
    // one burst that overfills the stack, occasional pop-downs past empty, some noise
    task automatic queue_random(input int n);
        int unsigned burst;
        int unsigned drain;
        int unsigned r;
        int unsigned depth;
        logic [CMD_W-1:0] c;
        burst = 0;
        drain = 0;
        for (int k = 0; k < n; k++) begin
            depth = stk_cnt[VIEW_GEN];
            r     = $urandom_range(0, 99);
            if (k == n / 3) burst = STACK_DEPTH - depth + 3;
            if (burst > 0) begin
                c = CMD_PUSH;
                burst--;
            end else if (drain > 0) begin
                c = CMD_FIN;
                drain--;
            end else if (r < 1) begin
                drain = depth + 1;
                c     = CMD_FIN;
            end else if (r < 7) begin
                c = CMD_W'($urandom_range(0, 7));
            end else if (depth < 2 && r < 80) begin
                c = CMD_PUSH;
            end else if (depth >= 2 && r < 50) begin
                c = CMD_PUSH;
            end else if (r < 92) begin
                c = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_DIV)));
            end else begin
                c = CMD_FIN;
            end
            queue_word(c, rand_q16());
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR: %s", what);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_bus.valid || predicted_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // command driver: a new word only once the previous one was taken
    always @(negedge i_clk) begin : drive_cmds
        calc_cmd_t nxt;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_took) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = cmd_backlog.pop_front();
                in_bus.valid         <= 1'b1;
                in_bus.cmd           <= nxt.cmd;
                in_bus.operand_value <= nxt.val;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off on request
    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_bus.ready <= 1'b0;
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end else begin
            out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: checks result words, predicts on every accepted command word
    always @(posedge i_clk) begin : watch_words
        calc_word_t exp;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= in_bus.valid && in_bus.ready;
            if (out_bus.valid && out_bus.ready) begin
                if (predicted_answers.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result: status %0d top %h depth %0d",
                                            out_bus.status, out_bus.top_value, out_bus.depth));
                end else begin
                    exp = predicted_answers.pop_front();
                    words_checked++;
                    status_hits[int'(exp.st)]++;
                    if (out_bus.status !== exp.st || out_bus.top_value !== exp.top ||
                        out_bus.depth !== exp.depth)
                        flag_mismatch($sformatf(
                            "got status %0d top %h depth %0d, expected status %0d top %h depth %0d",
                            out_bus.status, out_bus.top_value, out_bus.depth,
                            exp.st, exp.top, exp.depth));
                end
            end
            if (in_bus.valid && in_bus.ready) begin
                cmd_hits[in_bus.cmd]++;
                predicted_answers.push_back(
                    evaluate_word(VIEW_DUT, in_bus.cmd, in_bus.operand_value));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_test
        int unsigned send_pct [3];
        int unsigned recv_pct [3];
        send_pct = '{8, 74, 0};
        recv_pct = '{74, 8, 0};
        stk_cnt  = '{0, 0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-stack pops, unknown codes, saturation both ways,
        // zero divisor, divide overflow, floor rounding of the product
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        queue_word(CMD_FIN, Q_MAX);
        queue_word(CMD_DIV, '0);
        queue_word(CMD_ADD, Q_MIN);
        queue_word(CMD_UNK_LO, '0);
        queue_word(CMD_UNK_HI, Q_NEG_LSB);
        queue_word(CMD_FIN, '0);
        queue_word(CMD_PUSH, Q_MAX);
        queue_word(CMD_PUSH, Q_MAX);
        queue_word(CMD_ADD, '0);
        queue_word(CMD_PUSH, Q_MIN);
        queue_word(CMD_SUB, '0);
        queue_word(CMD_PUSH, Q_MIN);
        queue_word(CMD_PUSH, Q_LSB);
        queue_word(CMD_SUB, '0);
        queue_word(CMD_MUL, '0);
        queue_word(CMD_PUSH, Q_NEG_HALF);
        queue_word(CMD_MUL, '0);
        queue_word(CMD_PUSH, '0);
        queue_word(CMD_DIV, '0);
        queue_word(CMD_PUSH, Q_NEG_LSB);
        queue_word(CMD_DIV, '0);
        queue_word(CMD_PUSH, Q_LSB);
        queue_word(CMD_MUL, '0);
        queue_word(CMD_PUSH, Q_LSB);
        queue_word(CMD_MUL, '0);
        queue_word(CMD_FIN, '0);
        wait_drained();

        // random phases; each ends with the sender paused until all results are in
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            if (ph == 2) hold_req = 1'b1;    // long result stall with the sender pushing
            queue_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (predicted_answers.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", predicted_answers.size()));

        $display("Covered: push %0d, add %0d, sub %0d, mul %0d, div %0d, finish %0d, unknown %0d",
                 cmd_hits[CMD_PUSH], cmd_hits[CMD_ADD], cmd_hits[CMD_SUB], cmd_hits[CMD_MUL],
                 cmd_hits[CMD_DIV], cmd_hits[CMD_FIN], cmd_hits[CMD_UNK_LO] + cmd_hits[CMD_UNK_HI]);
        $display("Checked %0d results: full %0d, empty %0d, zero div %0d, saturated %0d; %0d bad",
                 words_checked, status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_ZDIV], status_hits[ST_OVF], mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_if.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_useq.sv
hw/rtl/rpn_stack_calculator_core.sv
dv/tb_rpn_stack_calculator_core.sv
